>>> design/foot_trajectory_generator_top_defines.svh
// Assertion macros shared by the foot trajectory generator checker.
`ifndef FOOT_TRAJECTORY_GENERATOR_TOP_DEFINES_SVH
`define FOOT_TRAJECTORY_GENERATOR_TOP_DEFINES_SVH

// Property that must hold at every clock edge outside reset.
`define FTG_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("foot trajectory generator check failed");

// Condition a must be followed in the next cycle by condition b.
`define FTG_ASSERT_NEXT(label, clk, rst, a, b) \
  `FTG_ASSERT(label, clk, rst, (a) |=> (b))

`endif

>>> design/ftg_pkg.sv
// Package with types, constants and sequencer codes of the foot trajectory generator.
package ftg_pkg;

  localparam int CW = 20;
  localparam int PHASE_BITS_DEF = 10;

  localparam logic [24:0] ONE_Q24 = 25'd16777216;
  localparam logic [23:0] STEP_MAX = 24'd16777215;
  localparam logic [31:0] C1_Q30 = 32'd1686629713;
  localparam logic [31:0] C3_Q30 = 32'd693598668;
  localparam logic [31:0] C5_Q30 = 32'd85569306;
  localparam logic [31:0] C7_Q30 = 32'd5026995;
  localparam logic [31:0] C9_Q30 = 32'd172272;
  localparam logic [16:0] K_ONE = 17'd65536;

  localparam int DIV_STEPS = 40;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  // Operation codes of an input request.
  localparam logic [1:0] OP_TICK    = 2'd0;
  localparam logic [1:0] OP_SET     = 2'd1;
  localparam logic [1:0] OP_HOLD    = 2'd2;
  localparam logic [1:0] OP_RELEASE = 2'd3;

  // Configuration register indexes.
  localparam logic [2:0] REG_HOME_X     = 3'd0;
  localparam logic [2:0] REG_HOME_Y     = 3'd1;
  localparam logic [2:0] REG_HOME_Z     = 3'd2;
  localparam logic [2:0] REG_TICK       = 3'd3;
  localparam logic [2:0] REG_MIN_DUR    = 3'd4;
  localparam logic [2:0] REG_SWING_THR  = 3'd5;

  localparam logic signed [CW-1:0] HOME_X_RST = 20'sd0;
  localparam logic signed [CW-1:0] HOME_Y_RST = 20'sd1311;
  localparam logic signed [CW-1:0] HOME_Z_RST = 20'sd13107;
  localparam logic [15:0] TICK_RST = 16'd655;
  localparam logic [19:0] MIN_DUR_RST = 20'd13107;
  localparam logic [18:0] SWING_THR_RST = 19'd328;

  // Sequencer steps; each step is both a controller state and a datapath command.
  localparam logic [5:0] ST_IDLE     = 6'd0;
  localparam logic [5:0] ST_SET      = 6'd1;
  localparam logic [5:0] ST_DIV      = 6'd2;
  localparam logic [5:0] ST_DIV_END  = 6'd3;
  localparam logic [5:0] ST_HOLD     = 6'd4;
  localparam logic [5:0] ST_RELEASE  = 6'd5;
  localparam logic [5:0] ST_TICK_FIN = 6'd6;
  localparam logic [5:0] ST_PHASE    = 6'd7;
  localparam logic [5:0] ST_M_UU     = 6'd8;
  localparam logic [5:0] ST_W_U2     = 6'd9;
  localparam logic [5:0] ST_M_R9     = 6'd10;
  localparam logic [5:0] ST_W_R7     = 6'd11;
  localparam logic [5:0] ST_M_R7     = 6'd12;
  localparam logic [5:0] ST_W_R5     = 6'd13;
  localparam logic [5:0] ST_M_R5     = 6'd14;
  localparam logic [5:0] ST_W_R3     = 6'd15;
  localparam logic [5:0] ST_M_R3     = 6'd16;
  localparam logic [5:0] ST_W_R1     = 6'd17;
  localparam logic [5:0] ST_M_UR     = 6'd18;
  localparam logic [5:0] ST_W_S      = 6'd19;
  localparam logic [5:0] ST_M_SS     = 6'd20;
  localparam logic [5:0] ST_W_K      = 6'd21;
  localparam logic [5:0] ST_M_CX     = 6'd22;
  localparam logic [5:0] ST_W_CX     = 6'd23;
  localparam logic [5:0] ST_M_CY     = 6'd24;
  localparam logic [5:0] ST_W_CY     = 6'd25;
  localparam logic [5:0] ST_M_CZ     = 6'd26;
  localparam logic [5:0] ST_W_CZ     = 6'd27;
  localparam logic [5:0] ST_M_BU     = 6'd28;
  localparam logic [5:0] ST_W_W0     = 6'd29;
  localparam logic [5:0] ST_M_BT     = 6'd30;
  localparam logic [5:0] ST_W_W2     = 6'd31;
  localparam logic [5:0] ST_M_B0     = 6'd32;
  localparam logic [5:0] ST_W_B0     = 6'd33;
  localparam logic [5:0] ST_M_B1     = 6'd34;
  localparam logic [5:0] ST_W_B1     = 6'd35;
  localparam logic [5:0] ST_M_B2     = 6'd36;
  localparam logic [5:0] ST_W_B2     = 6'd37;
  localparam logic [5:0] ST_OUT      = 6'd38;

  typedef struct packed {
    logic [1:0]           operation;
    logic signed [CW-1:0] dest_x;
    logic signed [CW-1:0] dest_y;
    logic signed [CW-1:0] dest_z;
    logic [19:0]          move_duration;
    logic signed [CW-1:0] lift_height;
  } in_item_t;

  typedef struct packed {
    logic signed [CW-1:0] pos_x;
    logic signed [CW-1:0] pos_y;
    logic signed [CW-1:0] pos_z;
    logic                 moving;
    logic                 holding;
  } out_item_t;

  typedef struct packed {
    logic [5:0] step;
    logic       take;
    logic       load_out;
  } cmd_t;

  typedef struct packed {
    logic phase_done;
    logic holding;
    logic swinging;
  } status_t;

endpackage

>>> design/ftg_ifs.sv
// Valid/ready channel interfaces for requests and results.
interface ftg_in_if;
  ftg_pkg::in_item_t data;
  logic              valid;
  logic              ready;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface ftg_out_if;
  ftg_pkg::out_item_t data;
  logic               valid;
  logic               ready;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> design/ftg_ctrl.sv
// Sequencer that steps the datapath through set, tick, hold and release requests.
module ftg_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic [1:0]       in_op,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  input  ftg_pkg::status_t status,
  output ftg_pkg::cmd_t    cmd
);

  logic [5:0]                    state;
  logic [5:0]                    state_next;
  logic [ftg_pkg::DIV_CNT_W-1:0] div_cnt;
  logic                          accept;
  logic                          load;

  assign in_ready = (state == ftg_pkg::ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign load     = (state == ftg_pkg::ST_OUT) && (!out_valid || out_ready);

  assign cmd.step     = state;
  assign cmd.take     = accept;
  assign cmd.load_out = load;

  always_comb begin
    state_next = state + 6'd1;
    case (state)
      ftg_pkg::ST_IDLE: begin
        state_next = ftg_pkg::ST_IDLE;
        if (accept) begin
          case (in_op)
            ftg_pkg::OP_TICK: begin
              if (status.holding) state_next = ftg_pkg::ST_OUT;
              else if (status.phase_done) state_next = ftg_pkg::ST_TICK_FIN;
              else state_next = ftg_pkg::ST_PHASE;
            end
            ftg_pkg::OP_SET: begin
              state_next = status.holding ? ftg_pkg::ST_OUT : ftg_pkg::ST_SET;
            end
            ftg_pkg::OP_HOLD: state_next = ftg_pkg::ST_HOLD;
            default: state_next = ftg_pkg::ST_RELEASE;
          endcase
        end
      end
      ftg_pkg::ST_DIV: begin
        if (div_cnt == ftg_pkg::DIV_CNT_W'(ftg_pkg::DIV_STEPS - 1))
          state_next = ftg_pkg::ST_DIV_END;
        else
          state_next = ftg_pkg::ST_DIV;
      end
      ftg_pkg::ST_DIV_END, ftg_pkg::ST_HOLD, ftg_pkg::ST_RELEASE,
      ftg_pkg::ST_TICK_FIN, ftg_pkg::ST_W_CZ: state_next = ftg_pkg::ST_OUT;
      ftg_pkg::ST_W_CY: begin
        state_next = status.swinging ? ftg_pkg::ST_M_BU : ftg_pkg::ST_M_CZ;
      end
      ftg_pkg::ST_OUT: state_next = load ? ftg_pkg::ST_IDLE : ftg_pkg::ST_OUT;
      default: state_next = state + 6'd1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ftg_pkg::ST_IDLE;
      div_cnt   <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ftg_pkg::ST_SET) div_cnt <= '0;
      else if (state == ftg_pkg::ST_DIV) div_cnt <= div_cnt + 1'b1;
      if (load) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

endmodule

>>> design/ftg_datapath.sv
// Datapath: state registers, shared multiplier, bit-serial divider and result register.
module ftg_datapath #(
  parameter int PHASE_BITS = ftg_pkg::PHASE_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  ftg_pkg::cmd_t             cmd,
  input  logic                      cfg_we,
  input  logic [2:0]                cfg_index,
  input  logic [19:0]               cfg_data,
  input  ftg_pkg::in_item_t         in_data,
  output ftg_pkg::status_t          status,
  output ftg_pkg::out_item_t        out_data
);

  localparam int CW = ftg_pkg::CW;

  logic signed [CW-1:0] home_x, home_y, home_z;
  logic [15:0]          tick_period;
  logic [19:0]          min_duration;
  logic [18:0]          swing_threshold;

  ftg_pkg::in_item_t    req;
  logic signed [CW-1:0] start_p [3];
  logic signed [CW-1:0] goal_p [3];
  logic signed [CW-1:0] cur_p [3];
  logic [24:0]          phase;
  logic [23:0]          step;
  logic signed [CW-1:0] lift;
  logic                 swinging;
  logic                 hold;

  logic [39:0]          dq;
  logic [20:0]          rem;
  logic [19:0]          dvs;
  logic [20:0]          rs;
  logic [19:0]          dur;

  logic [30:0]          u2;
  logic [31:0]          r;
  logic [30:0]          s;
  logic [16:0]          k;
  logic [24:0]          w0, w2;
  logic signed [25:0]   w1;
  logic signed [47:0]   bacc;
  logic signed [47:0]   bsum;

  logic signed [32:0]   ma, mb;
  logic signed [63:0]   prod;

  logic [PHASE_BITS:0]  idx;
  logic [30:0]          u;
  logic [24:0]          uu;
  logic [25:0]          psum;
  logic signed [CW:0]   dx, dy, dz, p1;
  logic signed [CW-1:0] zmin;
  logic [32:0]          s_raw;
  logic [19:0]          k_raw;

  function automatic logic signed [CW-1:0] sat(input logic signed [47:0] v);
    logic signed [47:0] hi, lo;
    hi = 48'sd1 <<< (CW - 1);
    hi = hi - 48'sd1;
    lo = -hi - 48'sd1;
    if (v > hi) return hi[CW-1:0];
    if (v < lo) return lo[CW-1:0];
    return v[CW-1:0];
  endfunction

  // Start plus eased delta, divided by 2^16 with truncation toward zero.
  function automatic logic signed [CW-1:0] cos_fin(input logic signed [CW-1:0] a,
                                                   input logic signed [63:0] p);
    logic signed [47:0] acc;
    acc = (48'(a) <<< 16) + p[47:0];
    if (acc < 0) acc = acc + 48'sd65535;
    return sat(acc >>> 16);
  endfunction

  assign idx  = phase[24:24-PHASE_BITS];
  assign u    = {idx, {(30-PHASE_BITS){1'b0}}};
  assign uu   = ftg_pkg::ONE_Q24 - phase;
  assign psum = {1'b0, phase} + {2'b0, step};
  assign dx   = {goal_p[0][CW-1], goal_p[0]} - {start_p[0][CW-1], start_p[0]};
  assign dy   = {goal_p[1][CW-1], goal_p[1]} - {start_p[1][CW-1], start_p[1]};
  assign dz   = {goal_p[2][CW-1], goal_p[2]} - {start_p[2][CW-1], start_p[2]};
  assign zmin = (start_p[2] < goal_p[2]) ? start_p[2] : goal_p[2];
  assign p1   = {zmin[CW-1], zmin} - {lift[CW-1], lift};
  assign w1   = 26'(ftg_pkg::ONE_Q24) - 26'(w0) - 26'(w2);
  assign rs   = {rem[19:0], dq[39]};
  assign dur  = (req.move_duration < min_duration) ? min_duration : req.move_duration;
  assign s_raw = prod[62:30];
  assign k_raw = prod[63:44];
  // Full signed Bezier sum of the three weighted control points.
  assign bsum = bacc + $signed(prod[47:0]);

  assign status.phase_done = phase[24];
  assign status.holding    = hold;
  assign status.swinging   = swinging;

  // Operand selection for the single shared multiplier.
  always_comb begin
    ma = '0;
    mb = '0;
    case (cmd.step)
      ftg_pkg::ST_M_UU: begin ma = 33'(u); mb = 33'(u); end
      ftg_pkg::ST_M_R9, ftg_pkg::ST_M_R7, ftg_pkg::ST_M_R5, ftg_pkg::ST_M_R3: begin
        ma = 33'(u2);
        mb = 33'(r);
      end
      ftg_pkg::ST_M_UR: begin ma = 33'(u); mb = 33'(r); end
      ftg_pkg::ST_M_SS: begin ma = 33'(s); mb = 33'(s); end
      ftg_pkg::ST_M_CX: begin ma = 33'(dx); mb = 33'(k); end
      ftg_pkg::ST_M_CY: begin ma = 33'(dy); mb = 33'(k); end
      ftg_pkg::ST_M_CZ: begin ma = 33'(dz); mb = 33'(k); end
      ftg_pkg::ST_M_BU: begin ma = 33'(uu); mb = 33'(uu); end
      ftg_pkg::ST_M_BT: begin ma = 33'(phase); mb = 33'(phase); end
      ftg_pkg::ST_M_B0: begin ma = 33'(w0); mb = 33'(start_p[2]); end
      ftg_pkg::ST_M_B1: begin ma = 33'(w1); mb = 33'(p1); end
      ftg_pkg::ST_M_B2: begin ma = 33'(w2); mb = 33'(goal_p[2]); end
      default: begin ma = '0; mb = '0; end
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= 64'(ma * mb);
    if (cmd.take) req <= in_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      home_x          <= ftg_pkg::HOME_X_RST;
      home_y          <= ftg_pkg::HOME_Y_RST;
      home_z          <= ftg_pkg::HOME_Z_RST;
      tick_period     <= ftg_pkg::TICK_RST;
      min_duration    <= ftg_pkg::MIN_DUR_RST;
      swing_threshold <= ftg_pkg::SWING_THR_RST;
      start_p[0] <= ftg_pkg::HOME_X_RST;
      start_p[1] <= ftg_pkg::HOME_Y_RST;
      start_p[2] <= ftg_pkg::HOME_Z_RST;
      goal_p[0]  <= ftg_pkg::HOME_X_RST;
      goal_p[1]  <= ftg_pkg::HOME_Y_RST;
      goal_p[2]  <= ftg_pkg::HOME_Z_RST;
      cur_p[0]   <= ftg_pkg::HOME_X_RST;
      cur_p[1]   <= ftg_pkg::HOME_Y_RST;
      cur_p[2]   <= ftg_pkg::HOME_Z_RST;
      phase      <= ftg_pkg::ONE_Q24;
      step       <= '0;
      lift       <= '0;
      swinging   <= 1'b0;
      hold       <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          ftg_pkg::REG_HOME_X:    home_x <= cfg_data;
          ftg_pkg::REG_HOME_Y:    home_y <= cfg_data;
          ftg_pkg::REG_HOME_Z:    home_z <= cfg_data;
          ftg_pkg::REG_TICK:      tick_period <= cfg_data[15:0];
          ftg_pkg::REG_MIN_DUR:   min_duration <= cfg_data;
          ftg_pkg::REG_SWING_THR: swing_threshold <= cfg_data[18:0];
          default: ;
        endcase
      end
      case (cmd.step)
        ftg_pkg::ST_SET: begin
          start_p[0] <= cur_p[0];
          start_p[1] <= cur_p[1];
          start_p[2] <= cur_p[2];
          goal_p[0]  <= req.dest_x;
          goal_p[1]  <= req.dest_y;
          goal_p[2]  <= req.dest_z;
          lift       <= req.lift_height;
          swinging   <= $signed({req.lift_height[CW-1], req.lift_height})
                        > $signed({2'b0, swing_threshold});
          phase      <= '0;
          dq         <= {tick_period, 24'b0};
          rem        <= '0;
          dvs        <= (dur == '0) ? 20'd1 : dur;
        end
        ftg_pkg::ST_DIV: begin
          if (rs >= {1'b0, dvs}) begin
            rem <= rs - {1'b0, dvs};
            dq  <= {dq[38:0], 1'b1};
          end else begin
            rem <= rs;
            dq  <= {dq[38:0], 1'b0};
          end
        end
        ftg_pkg::ST_DIV_END: step <= (dq[39:24] != '0) ? ftg_pkg::STEP_MAX : dq[23:0];
        ftg_pkg::ST_HOLD: begin
          start_p[0] <= home_x;
          start_p[1] <= home_y;
          start_p[2] <= home_z;
          goal_p[0]  <= home_x;
          goal_p[1]  <= home_y;
          goal_p[2]  <= home_z;
          cur_p[0]   <= home_x;
          cur_p[1]   <= home_y;
          cur_p[2]   <= home_z;
          phase      <= ftg_pkg::ONE_Q24;
          step       <= '0;
          lift       <= '0;
          swinging   <= 1'b0;
          hold       <= 1'b1;
        end
        ftg_pkg::ST_RELEASE: hold <= 1'b0;
        ftg_pkg::ST_TICK_FIN: begin
          cur_p[0] <= goal_p[0];
          cur_p[1] <= goal_p[1];
          cur_p[2] <= goal_p[2];
        end
        ftg_pkg::ST_PHASE: begin
          phase <= (psum > 26'(ftg_pkg::ONE_Q24)) ? ftg_pkg::ONE_Q24 : psum[24:0];
        end
        ftg_pkg::ST_W_U2: begin
          u2 <= prod[60:30];
          r  <= ftg_pkg::C9_Q30;
        end
        ftg_pkg::ST_W_R7: r <= ftg_pkg::C7_Q30 - prod[61:30];
        ftg_pkg::ST_W_R5: r <= ftg_pkg::C5_Q30 - prod[61:30];
        ftg_pkg::ST_W_R3: r <= ftg_pkg::C3_Q30 - prod[61:30];
        ftg_pkg::ST_W_R1: r <= ftg_pkg::C1_Q30 - prod[61:30];
        ftg_pkg::ST_W_S: s <= (s_raw > 33'd1073741824) ? 31'd1073741824 : s_raw[30:0];
        ftg_pkg::ST_W_K: begin
          if (idx == '0) k <= '0;
          else if (idx[PHASE_BITS]) k <= ftg_pkg::K_ONE;
          else if (k_raw > 20'(ftg_pkg::K_ONE)) k <= ftg_pkg::K_ONE;
          else k <= k_raw[16:0];
        end
        ftg_pkg::ST_W_CX: cur_p[0] <= cos_fin(start_p[0], prod);
        ftg_pkg::ST_W_CY: cur_p[1] <= cos_fin(start_p[1], prod);
        ftg_pkg::ST_W_CZ: cur_p[2] <= cos_fin(start_p[2], prod);
        ftg_pkg::ST_W_W0: w0 <= prod[48:24];
        ftg_pkg::ST_W_W2: w2 <= prod[48:24];
        ftg_pkg::ST_W_B0: bacc <= prod[47:0];
        ftg_pkg::ST_W_B1: bacc <= bacc + prod[47:0];
        ftg_pkg::ST_W_B2: begin
          if (bsum < 0)
            cur_p[2] <= sat((bsum + 48'sd16777215) >>> 24);
          else
            cur_p[2] <= sat(bsum >>> 24);
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_data.pos_x   <= cur_p[0];
      out_data.pos_y   <= cur_p[1];
      out_data.pos_z   <= cur_p[2];
      out_data.moving  <= !phase[24];
      out_data.holding <= hold;
    end
  end

endmodule

>>> design/foot_trajectory_generator_top.sv
// Top level of the foot trajectory generator for one leg.
// A set target runs the bit-serial divider for the phase step; a tick in motion runs cosine
// easing for x and y and cosine easing or a swing arc for z; a tick after the finish, a hold
// and a release take short paths, and a tick or set target during a hold is ignored and only
// returns the held result. One request is in work at a time; the next is taken the cycle after
// its result is registered. Synchronous active-high reset restores home and defaults.
module foot_trajectory_generator_top #(
  parameter int PHASE_BITS = ftg_pkg::PHASE_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [19:0] cfg_data,
  ftg_in_if.sink      item,
  ftg_out_if.source   result
);

  // Command and status between the sequencer and the datapath.
  ftg_pkg::cmd_t    cmd;
  ftg_pkg::status_t status;

  // The controller walks a list of steps chosen per request: a set target runs the restoring
  // divider for the phase step, an unfinished tick runs the easing polynomial by Horner on the shared
  // multiplier, then the x and y blends and the z blend or swing arc, and a hold reloads home.
  ftg_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (item.valid),
    .in_op     (item.data.operation),
    .in_ready  (item.ready),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .status    (status),
    .cmd       (cmd)
  );

  // The datapath owns every register of the leg state and the result register, so a
  // finished result can wait for the consumer while the next request is accepted.
  ftg_datapath #(
    .PHASE_BITS (PHASE_BITS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (item.data),
    .status    (status),
    .out_data  (result.data)
  );

endmodule

>>> design/ftg_checker.sv
// Port-level checker for the foot trajectory generator and its bind.
`include "foot_trajectory_generator_top_defines.svh"

module ftg_checker (
  input logic clk,
  input logic rst,
  input logic item_valid,
  input logic item_ready,
  input logic result_valid,
  input logic result_ready,
  input logic result_moving,
  input logic result_holding
);

  // One request at a time: after an accept the input side must close.
  `FTG_ASSERT_NEXT(a_one_in_flight, clk, rst, item_valid && item_ready, !item_ready)
  // A held leg is parked at home with the phase finished.
  `FTG_ASSERT(a_hold_not_moving, clk, rst, result_valid && result_holding |-> !result_moving)
  `FTG_ASSERT_NEXT(a_result_stays, clk, rst, result_valid && !result_ready, result_valid)
  `FTG_ASSERT_NEXT(a_hold_stable, clk, rst, result_valid && !result_ready,
                   $stable(result_holding))

endmodule

bind foot_trajectory_generator_top ftg_checker u_ftg_checker (
  .clk            (clk),
  .rst            (rst),
  .item_valid     (item.valid),
  .item_ready     (item.ready),
  .result_valid   (result.valid),
  .result_ready   (result.ready),
  .result_moving  (result.data.moving),
  .result_holding (result.data.holding)
);
